[rtl/mpp_pkg.sv]
// Shared types and constants for the metric packet parser.
package mpp_pkg;

    localparam int POS_W       = 9;
    localparam int POS_MAX     = 511;
    localparam int STAMP_FIRST = 2;
    localparam int LEN_POS     = 10;
    localparam int HDR_LEN     = 11;
    localparam int WORD_LEN    = 8;
    localparam int QUEUE_DEPTH = 4;

    // m_tdata: 161 bits of fields, padded to whole bytes
    localparam int OUT_BITS    = 161;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_MAGIC   = 2'd0;
    localparam cfg_idx_t CFG_COUNTER = 2'd1;
    localparam cfg_idx_t CFG_GAUGE   = 2'd2;

    localparam logic [7:0] MAGIC_RESET   = 8'd0;
    localparam logic [7:0] COUNTER_RESET = 8'd0;
    localparam logic [7:0] GAUGE_RESET   = 8'd1;

    // What a packet byte means, decided by the front end
    typedef enum logic [2:0] {
        OP_MAGIC,
        OP_TYPE,
        OP_STAMP,
        OP_LEN,
        OP_NAME,
        OP_VALUE,
        OP_SKIP
    } mpp_op_t;

    typedef struct packed {
        mpp_op_t    op;
        logic [7:0] data;
        logic [7:0] name_index;
        logic       last;
        logic       hdr_bad;    // magic or type mismatch on this byte
        logic       count_bad;  // byte count check fails (only meaningful when last)
    } mpp_item_t;

endpackage

[rtl/mpp_front.sv]
// Front end: configuration registers, position tracking and byte classification.
module mpp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  mpp_pkg::cfg_idx_t   cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                queue_full,
    output logic                push,
    output mpp_pkg::mpp_item_t  push_item
);
    import mpp_pkg::*;

    logic [7:0]       magic_reg;
    logic [7:0]       counter_reg;
    logic [7:0]       gauge_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       len_reg;
    logic [7:0]       len_next;
    logic [9:0]       pos_ext;
    logic [9:0]       name_end;
    logic [9:0]       value_end;
    mpp_item_t        item;

    assign cfg_ready = 1'b1;
    assign s_tready  = !queue_full;
    assign push      = s_tvalid && s_tready;
    assign push_item = item;

    assign pos_ext   = {1'b0, pos_reg};
    assign name_end  = 10'(HDR_LEN) + {2'b00, len_reg};
    assign value_end = name_end + 10'(WORD_LEN);

    always_comb
    begin
        item.op         = OP_SKIP;
        item.data       = s_tdata;
        item.name_index = 8'(pos_ext - 10'(HDR_LEN));
        item.last       = s_tlast;
        item.hdr_bad    = 1'b0;
        // total count is pos+1 and must be header + name + value word
        item.count_bad  = (pos_ext == 10'(POS_MAX)) || (pos_ext + 10'd1 != value_end);
        len_next        = len_reg;

        if (pos_ext == 10'd0)
        begin
            item.op      = OP_MAGIC;
            item.hdr_bad = (s_tdata != magic_reg);
        end
        else if (pos_ext == 10'd1)
        begin
            item.op      = OP_TYPE;
            item.hdr_bad = (s_tdata != counter_reg) && (s_tdata != gauge_reg);
        end
        else if (pos_ext >= 10'(STAMP_FIRST) && pos_ext < 10'(LEN_POS))
        begin
            item.op = OP_STAMP;
        end
        else if (pos_ext == 10'(LEN_POS))
        begin
            item.op  = OP_LEN;
            len_next = s_tdata;
        end
        else if (pos_ext >= 10'(HDR_LEN) && pos_ext < name_end)
        begin
            item.op = OP_NAME;
        end
        else if (pos_ext >= name_end && pos_ext < value_end)
        begin
            item.op = OP_VALUE;
        end

        if (s_tlast)
        begin
            pos_next = '0;
            len_next = '0;
        end
        else if (pos_ext < 10'(POS_MAX))
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= MAGIC_RESET;
            counter_reg <= COUNTER_RESET;
            gauge_reg   <= GAUGE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAGIC:   magic_reg   <= cfg_data;
                CFG_COUNTER: counter_reg <= cfg_data;
                CFG_GAUGE:   gauge_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

endmodule

[rtl/mpp_queue.sv]
// Short queue of classified bytes between front and back end.
module mpp_queue
#(
    parameter int DEPTH = mpp_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mpp_pkg::mpp_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output mpp_pkg::mpp_item_t  head_item
);
    import mpp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mpp_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/mpp_back.sv]
// Back end: field assembly, status tracking and the output register.
module mpp_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  mpp_pkg::mpp_item_t            head_item,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mpp_pkg::OUT_W-1:0]     m_tdata,  // name_char, name_index, metric_type,
                                                    // stamp, value_word, name_length, status
    output logic                          m_tlast   // kind: 1 done item
);
    import mpp_pkg::*;

    logic [7:0]       type_reg,   type_next;
    logic [63:0]      stamp_reg,  stamp_next;
    logic [63:0]      value_reg,  value_next;
    logic [7:0]       len_reg,    len_next;
    logic             bad_reg,    bad_next;
    logic             split_reg,  split_next;   // name item of a final name byte is out
    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg,  out_kind_next;
    logic [OUT_W-1:0] out_data_reg,  out_data_next;
    logic             slot_free;
    logic             needs_out;
    logic             apply;
    logic             emit_name;
    logic             emit_done;
    logic [7:0]       upd_type;
    logic [63:0]      upd_stamp;
    logic [63:0]      upd_value;
    logic [7:0]       upd_len;
    logic             upd_bad;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_kind_reg;

    assign slot_free = !out_valid_reg || m_tready;
    assign needs_out = (head_item.op == OP_NAME) || head_item.last;

    // state as it stands once the head byte is applied
    always_comb
    begin
        upd_type  = type_reg;
        upd_stamp = stamp_reg;
        upd_value = value_reg;
        upd_len   = len_reg;
        upd_bad   = bad_reg | head_item.hdr_bad;
        case (head_item.op)
            OP_TYPE:  upd_type  = head_item.data;
            OP_STAMP: upd_stamp = {stamp_reg[55:0], head_item.data};
            OP_LEN:   upd_len   = head_item.data;
            OP_VALUE: upd_value = {value_reg[55:0], head_item.data};
            default:  ;
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        apply          = 1'b0;
        emit_name      = 1'b0;
        emit_done      = 1'b0;
        split_next     = split_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;

        if (slot_free)
        begin
            out_valid_next = 1'b0;
        end

        if (head_valid)
        begin
            if (!needs_out)
            begin
                pop   = 1'b1;
                apply = 1'b1;
            end
            else if (slot_free)
            begin
                if (head_item.op == OP_NAME && !split_reg)
                begin
                    emit_name = 1'b1;
                    if (head_item.last)
                    begin
                        split_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    emit_done  = 1'b1;
                    split_next = 1'b0;
                    pop        = 1'b1;
                    apply      = 1'b1;
                end
            end
        end

        if (emit_name)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = 1'b0;
            out_data_next  = OUT_W'({head_item.name_index, head_item.data});
        end
        else if (emit_done)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = 1'b1;
            out_data_next  = OUT_W'({upd_bad | head_item.count_bad, upd_len, upd_value,
                                     upd_stamp, upd_type, 16'h0000});
        end

        type_next  = type_reg;
        stamp_next = stamp_reg;
        value_next = value_reg;
        len_next   = len_reg;
        bad_next   = bad_reg;
        if (apply)
        begin
            if (head_item.last)
            begin
                type_next  = '0;
                stamp_next = '0;
                value_next = '0;
                len_next   = '0;
                bad_next   = 1'b0;
            end
            else
            begin
                type_next  = upd_type;
                stamp_next = upd_stamp;
                value_next = upd_value;
                len_next   = upd_len;
                bad_next   = upd_bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg      <= '0;
            stamp_reg     <= '0;
            value_reg     <= '0;
            len_reg       <= '0;
            bad_reg       <= 1'b0;
            split_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 1'b0;
        end
        else
        begin
            type_reg      <= type_next;
            stamp_reg     <= stamp_next;
            value_reg     <= value_next;
            len_reg       <= len_next;
            bad_reg       <= bad_next;
            split_reg     <= split_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

[rtl/metric_packet_parser.sv]
// Top level of the metric packet parser.
//
// Packet bytes enter on the s_ channel, one item per byte, s_tlast on the
// final byte. Results leave on the m_ channel: a name byte item (m_tlast low)
// for each name byte, and a done item (m_tlast high) after the final byte with
// type, timestamp, raw value bits, name length and status (1 = bad packet).
// When the final byte is itself a name byte, its name item goes first.
// Configuration (magic, counter code, gauge code) is written on cfg_; the user
// must write it only while idle, which the block does not enforce. cfg_ready
// is always high. One byte per cycle is taken while m_tready stays high; a
// final byte that is also a name byte gives two output items, one at a time.
// A result passes through the queue and then the output register.
// The front end classifies bytes into a queue of QUEUE_DEPTH entries; the back
// end assembles fields and drives the output register. If m_tready stays low,
// the queue fills and s_tready drops. Reset clears all packet state and loads
// the configuration defaults.
module metric_packet_parser
#(
    parameter int QUEUE_DEPTH = mpp_pkg::QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // data_byte
    input  logic                        s_tlast,   // end_of_packet
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mpp_pkg::OUT_W-1:0]   m_tdata,   // name_char, name_index, metric_type,
                                                   // stamp, value_word, name_length, status
    output logic                        m_tlast,   // kind
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  mpp_pkg::cfg_idx_t           cfg_index,
    input  logic [7:0]                  cfg_data
);
    import mpp_pkg::*;

    logic      push;
    logic      queue_full;
    logic      pop;
    logic      head_valid;
    mpp_item_t push_item;
    mpp_item_t head_item;

    mpp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    mpp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    mpp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[verif/tb_metric_packet_parser.sv]
// Self-checking testbench for metric_packet_parser: directed and random packets.
`timescale 1ns / 100ps

module tb_metric_packet_parser;
    import mpp_pkg::*;

    // m_tdata fields, lowest bits last in the declaration
    typedef struct packed {
        logic [OUT_W-OUT_BITS-1:0] pad;
        logic                      status;
        logic [7:0]                name_length;
        logic [63:0]               value_word;
        logic [63:0]               stamp;
        logic [7:0]                metric_type;
        logic [7:0]                name_index;
        logic [7:0]                name_char;
    } packet_fields_t;

    typedef struct {
        logic           kind;
        packet_fields_t f;
    } parse_result_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       typed;       // status of the done item typed in below
        logic       want_status;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;     // data_byte
    logic             s_tlast;     // end_of_packet
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;     // name_char, name_index, metric_type, stamp,
                                   // value_word, name_length, status, zero pad
    logic             m_tlast;     // kind
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_idx_t         cfg_index;
    logic [7:0]       cfg_data;

    // parser image
    logic [7:0]  cfg_magic   = MAGIC_RESET;
    logic [7:0]  cfg_counter = COUNTER_RESET;
    logic [7:0]  cfg_gauge   = GAUGE_RESET;
    int          pkt_pos     = 0;
    logic        pkt_bad     = 1'b0;
    logic [7:0]  pkt_type    = '0;
    logic [63:0] pkt_stamp   = '0;
    logic [7:0]  pkt_len     = '0;
    logic [63:0] pkt_value   = '0;

    parse_result_t expected_results [$];
    int            errors     = 0;
    int            items_sent = 0;
    int            gap_odds   = 4;
    logic          calm       = 1'b0;
    logic          sink_quiet = 1'b0;

    // one-byte packet, two-byte packet, bad header whose final byte is a name byte
    stim_row_t directed_rows [15] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1},
        '{8'h00, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b1, 1'b1, 1'b1},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b1}
    };

    metric_packet_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic predict_byte(input logic [7:0] b, input logic last,
                                input logic typed, input logic want_status);
        parse_result_t r;
        int            p;
        int            name_end;
        p = pkt_pos;
        name_end = HDR_LEN + pkt_len;
        if (p == 0)
        begin
            if (b != cfg_magic)
                pkt_bad = 1'b1;
        end
        else if (p == 1)
        begin
            pkt_type = b;
            if (b != cfg_counter && b != cfg_gauge)
                pkt_bad = 1'b1;
        end
        else if (p >= STAMP_FIRST && p < LEN_POS)
            pkt_stamp = {pkt_stamp[55:0], b};
        else if (p == LEN_POS)
            pkt_len = b;
        else if (p >= HDR_LEN && p < name_end)
        begin
            r.kind = 1'b0;
            r.f = '0;
            r.f.name_char = b;
            r.f.name_index = 8'(p - HDR_LEN);
            expected_results.push_back(r);
        end
        else if (p >= name_end && p < name_end + WORD_LEN)
            pkt_value = {pkt_value[55:0], b};

        if (pkt_pos < POS_MAX)
            pkt_pos++;

        if (last)
        begin
            r.kind = 1'b1;
            r.f = '0;
            r.f.metric_type = pkt_type;
            r.f.stamp = pkt_stamp;
            r.f.value_word = pkt_value;
            r.f.name_length = pkt_len;
            // a saturated position never matches the expected byte count
            r.f.status = pkt_bad || p >= POS_MAX || (p + 1 != HDR_LEN + pkt_len + WORD_LEN);
            if (typed)
                r.f.status = want_status;
            expected_results.push_back(r);
            pkt_pos = 0;
            pkt_bad = 1'b0;
            pkt_type = '0;
            pkt_stamp = '0;
            pkt_len = '0;
            pkt_value = '0;
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        parse_result_t  e;
        packet_fields_t got;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got = m_tdata;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, got kind %b data %h",
                         $time, m_tlast, m_tdata);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("kind", e.kind, m_tlast);
                check_field("name_char", e.f.name_char, got.name_char);
                check_field("name_index", e.f.name_index, got.name_index);
                check_field("metric_type", e.f.metric_type, got.metric_type);
                check_field("stamp", e.f.stamp, got.stamp);
                check_field("value_word", e.f.value_word, got.value_word);
                check_field("name_length", e.f.name_length, got.name_length);
                check_field("status", e.f.status, got.status);
            end
        end
    end

    task automatic feed_byte(input logic [7:0] b, input logic last,
                             input logic typed, input logic want_status);
        int n;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        items_sent++;
        predict_byte(b, last, typed, want_status);
    endtask

    // header built from the current codes unless corrupted; force_len fixes the byte count
    task automatic send_packet(input int force_len);
        logic [7:0] body [$];
        int         mode;
        int         nlen;
        int         total;
        int         k;
        mode = (force_len > 0) ? 50 : $urandom_range(0, 99);
        if ($urandom_range(0, 39) == 0)
            nlen = $urandom_range(0, 1) ? 255 : $urandom_range(100, 254);
        else
            nlen = $urandom_range(0, 8);
        body.push_back(mode < 8 ? 8'($urandom) : cfg_magic);
        if (mode >= 8 && mode < 16)
            body.push_back(8'($urandom));
        else
            body.push_back($urandom_range(0, 1) ? cfg_counter : cfg_gauge);
        repeat (8) body.push_back(8'($urandom));
        body.push_back(8'(nlen));
        repeat (nlen + WORD_LEN) body.push_back(8'($urandom));
        total = body.size();
        if (force_len > 0)
            total = force_len;
        else if (mode >= 80 && mode < 90)
            total = $urandom_range(1, body.size());
        else if (mode >= 90)
            total = body.size() + $urandom_range(1, 12);
        while (body.size() < total)
            body.push_back(8'($urandom));
        gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 20);
        for (k = 0; k < total; k++)
            feed_byte(body[k], k == total - 1, 1'b0, 1'b0);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_settings(input logic [7:0] magic, input logic [7:0] counter,
                                 input logic [7:0] gauge);
        cfg_idx_t   regs [3];
        logic [7:0] vals [3];
        int         k;
        regs = '{CFG_MAGIC, CFG_COUNTER, CFG_GAUGE};
        vals = '{magic, counter, gauge};
        for (k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data <= vals[k];
            @(posedge clk);
            while (cfg_ready !== 1'b1)
                @(posedge clk);
            case (regs[k])
                CFG_MAGIC:   cfg_magic = vals[k];
                CFG_COUNTER: cfg_counter = vals[k];
                default:     cfg_gauge = vals[k];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: random stall bursts, with quiet stretches
    initial
    begin
        int n;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                sink_quiet = !sink_quiet;
            if (!calm && !sink_quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        int ph;
        int quota;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MAGIC;
        cfg_data <= '0;
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            feed_byte(directed_rows[k].b, directed_rows[k].last,
                      directed_rows[k].typed, directed_rows[k].want_status);
        settle();

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: load_settings(8'hFF, 8'hFF, 8'h00);
                1: load_settings(8'h00, 8'h00, 8'h00);
                2: load_settings(8'($urandom), 8'($urandom), 8'($urandom));
                3: load_settings(8'($urandom), 8'($urandom), 8'hFF);
                default:
                begin
                    calm = 1'b1;
                    load_settings(8'($urandom), 8'($urandom), 8'($urandom));
                end
            endcase
            quota = items_sent + 80;
            // one packet long enough to pin the position counter
            if (ph == 2)
                send_packet($urandom_range(512, 530));
            while (items_sent < quota)
                send_packet(0);
            settle();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/mpp_pkg.sv
rtl/mpp_front.sv
rtl/mpp_queue.sv
rtl/mpp_back.sv
rtl/metric_packet_parser.sv
verif/tb_metric_packet_parser.sv
